### rtl/atrf_pkg.sv
package atrf_pkg;

    // Sizing of the ring, the prices and the smoothing factor.
    localparam int MAX_WINDOW  = 64;
    localparam int PRICE_WIDTH = 32;
    localparam int ALPHA_BITS  = 16;

    localparam int IDX_W      = $clog2(MAX_WINDOW);
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int TRI_MAX    = MAX_WINDOW * (MAX_WINDOW + 1) / 2;
    localparam int DV_W       = $clog2(TRI_MAX + 1);
    localparam int SUM_W      = PRICE_WIDTH + $clog2(MAX_WINDOW);
    localparam int WSUM_W     = PRICE_WIDTH + DV_W;
    localparam int DCNT_W     = $clog2(WSUM_W + 1);
    localparam int ALPHA_W    = ALPHA_BITS + 1;
    localparam int MODE_W     = 2;
    localparam int WLEN_W     = 7;
    localparam int ADDR_W     = 4;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << ALPHA_BITS;

    // Smoothing modes; any other code runs the simple average.
    localparam logic [MODE_W-1:0] MODE_WEIGHTED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EMA      = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_WLEN  = 2'd1;
    localparam logic [1:0] REG_ALPHA = 2'd2;

    typedef struct packed {
        logic load;
        logic ema_mul;
        logic ema_upd;
        logic sum_start;
        logic div_start;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic ema_mode;
        logic full;
        logic sum_done;
        logic div_done;
    } dp_stat_t;

endpackage

### rtl/average_true_range_filter_core.sv
// Channel  | Ports                    | Carries
// ---------+--------------------------+------------------------------------------
// input    | s_tvalid/s_tready/s_tdata| one price bar per request, start flag in
//          | s_tuser                  | s_tuser
// result   | m_tvalid/m_tready/m_tdata| one smoothed range per bar, window-full
//          | m_tuser                  | flag in m_tuser
// config   | psel/penable/pwrite/...  | mode, window length, smoothing factor
//
// In the exponential mode or while the window is still filling, a bar passes
// the load, EMA and finish steps only. With a full window the window walk
// then reads one ring entry per cycle through a single read port, and the
// restoring divider then retires one quotient bit per cycle over 44 bits.
// Reset is synchronous and active low; it clears the series state, the
// registers return to mode 0, N = 14, alpha = 8738. A stalled result sits in
// the output register while the next bar is already accepted and processed.
module average_true_range_filter_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [31:0] high_price, [63:32] low_price, [95:64] close_price
    input  logic [3*atrf_pkg::PRICE_WIDTH-1:0]   s_tdata,
    // [0] start_series
    input  logic                                 s_tuser,

    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [31:0] atr_value, [63:32] bar_range
    output logic [2*atrf_pkg::PRICE_WIDTH-1:0]   m_tdata,
    // [0] window_full
    output logic                                 m_tuser,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [atrf_pkg::ADDR_W-1:0]          paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    localparam int PW = atrf_pkg::PRICE_WIDTH;

    // Configuration registers.
    logic [atrf_pkg::MODE_W-1:0]  mode_reg;
    logic [atrf_pkg::WLEN_W-1:0]  wlen_reg;
    logic [atrf_pkg::ALPHA_W-1:0] alpha_reg;

    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= '0;
            wlen_reg  <= atrf_pkg::WLEN_W'(14);
            alpha_reg <= atrf_pkg::ALPHA_W'(8738);
        end else if (wr_en) begin
            unique case (reg_idx)
                atrf_pkg::REG_MODE:  mode_reg  <= pwdata[atrf_pkg::MODE_W-1:0];
                atrf_pkg::REG_WLEN:  wlen_reg  <= pwdata[atrf_pkg::WLEN_W-1:0];
                atrf_pkg::REG_ALPHA: alpha_reg <= pwdata[atrf_pkg::ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back is combinational; unknown addresses read zero.
    always_comb begin
        unique case (reg_idx)
            atrf_pkg::REG_MODE:  prdata = 32'(mode_reg);
            atrf_pkg::REG_WLEN:  prdata = 32'(wlen_reg);
            atrf_pkg::REG_ALPHA: prdata = 32'(alpha_reg);
            default:             prdata = '0;
        endcase
    end

    atrf_pkg::dp_cmd_t  cmd;
    atrf_pkg::dp_stat_t stat;

    // The controller sequences each bar; the datapath owns the ring, the
    // running sums, the smoothing multipliers and the divider.
    atrf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    atrf_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .mode         (mode_reg),
        .wlen         (wlen_reg),
        .alpha        (alpha_reg),
        .high_price   (s_tdata[PW-1:0]),
        .low_price    (s_tdata[2*PW-1:PW]),
        .close_price  (s_tdata[3*PW-1:2*PW]),
        .start_series (s_tuser),
        .atr_value    (m_tdata[PW-1:0]),
        .bar_range    (m_tdata[2*PW-1:PW]),
        .window_full  (m_tuser)
    );

endmodule

### rtl/atrf_ctrl.sv
module atrf_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output atrf_pkg::dp_cmd_t  cmd,
    input  atrf_pkg::dp_stat_t stat
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EMA1 = 7'b0000010,
        S_EMA2 = 7'b0000100,
        S_SUM  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_WAIT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;

    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg & ~m_tready;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EMA1;
                end
            end
            S_EMA1: begin
                cmd.ema_mul = 1'b1;
                state_next  = S_EMA2;
            end
            S_EMA2: begin
                cmd.ema_upd = 1'b1;
                if (stat.ema_mode || !stat.full) begin
                    state_next = S_FIN;
                end else begin
                    cmd.sum_start = 1'b1;
                    state_next    = S_SUM;
                end
            end
            S_SUM: begin
                if (stat.sum_done) begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                if (stat.div_done) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

### rtl/atrf_datapath.sv
module atrf_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  atrf_pkg::dp_cmd_t                    cmd,
    output atrf_pkg::dp_stat_t                   stat,
    input  logic [atrf_pkg::MODE_W-1:0]          mode,
    input  logic [atrf_pkg::WLEN_W-1:0]          wlen,
    input  logic [atrf_pkg::ALPHA_W-1:0]         alpha,
    input  logic [atrf_pkg::PRICE_WIDTH-1:0]     high_price,
    input  logic [atrf_pkg::PRICE_WIDTH-1:0]     low_price,
    input  logic [atrf_pkg::PRICE_WIDTH-1:0]     close_price,
    input  logic                                 start_series,
    output logic [atrf_pkg::PRICE_WIDTH-1:0]     atr_value,
    output logic [atrf_pkg::PRICE_WIDTH-1:0]     bar_range,
    output logic                                 window_full
);

    localparam int PW  = atrf_pkg::PRICE_WIDTH;
    localparam int IW  = atrf_pkg::IDX_W;
    localparam int CW  = atrf_pkg::CNT_W;
    localparam int DW  = atrf_pkg::DV_W;
    localparam int WW  = atrf_pkg::WSUM_W;
    localparam int SW  = atrf_pkg::SUM_W;
    localparam int AW  = atrf_pkg::ALPHA_W;
    localparam int EPW = PW + AW;

    logic [PW-1:0] ring [atrf_pkg::MAX_WINDOW];

    logic [IW-1:0] head_reg;
    logic [CW-1:0] seen_reg;
    logic [PW-1:0] prev_reg, tr_reg, ema_reg;
    logic          first_reg;
    logic [EPW-1:0] pa_reg, pb_reg;

    logic [IW-1:0] rptr_reg;
    logic [CW-1:0] left_reg, wt_reg, rwt_reg;
    logic          rvld_reg, pvld_reg;
    logic [PW-1:0] rdata_reg, pdata_reg;
    logic [PW+CW-1:0] prod_reg;
    logic [SW-1:0] sum_reg;
    logic [WW-1:0] wsum_reg;

    logic [DW-1:0]     dvsr_reg, rem_reg;
    logic [WW-1:0]     quo_reg;
    logic [atrf_pkg::DCNT_W-1:0] dcnt_reg;

    logic [PW-1:0] atr_reg, tro_reg;
    logic          full_o_reg;

    // Effective window and smoothing factor after clamping.
    logic [CW-1:0] n_eff;
    logic [AW-1:0] a_eff;
    always_comb begin
        if (wlen == '0) begin
            n_eff = CW'(1);
        end else if (int'(wlen) > atrf_pkg::MAX_WINDOW) begin
            n_eff = CW'(atrf_pkg::MAX_WINDOW);
        end else begin
            n_eff = CW'(wlen);
        end
        a_eff = (alpha > atrf_pkg::ALPHA_ONE) ? atrf_pkg::ALPHA_ONE : alpha;
    end

    logic full;
    assign full = (seen_reg >= n_eff);
    logic weighted;
    assign weighted = (mode == atrf_pkg::MODE_WEIGHTED);

    // True range of the incoming bar.
    logic          first_c;
    logic [PW-1:0] base_c, t1_c, t2_c, tr_c;
    always_comb begin
        first_c = start_series || (seen_reg == '0);
        base_c  = (high_price >= low_price) ? (high_price - low_price) : '0;
        t1_c    = (high_price >= prev_reg) ? (high_price - prev_reg) : (prev_reg - high_price);
        t2_c    = (low_price >= prev_reg) ? (low_price - prev_reg) : (prev_reg - low_price);
        tr_c    = base_c;
        if (!first_c) begin
            if (t1_c > tr_c) tr_c = t1_c;
            if (t2_c > tr_c) tr_c = t2_c;
        end
    end

    logic [EPW:0] ema_sum;
    assign ema_sum = (EPW+1)'(pa_reg) + (EPW+1)'(pb_reg)
                   + ((EPW+1)'(1) << (atrf_pkg::ALPHA_BITS - 1));

    // Divisor: N, or N(N+1)/2 in the weighted mode.
    logic [2*CW+1:0] n_wide, tri_prod;
    assign n_wide   = (2*CW+2)'(n_eff);
    assign tri_prod = n_wide * (n_wide + 1'b1);

    // One restoring divide step.
    logic [DW:0]   shift_rem;
    logic [DW+1:0] trial;
    assign shift_rem = {rem_reg, quo_reg[WW-1]};
    assign trial     = (DW+2)'(shift_rem) - (DW+2)'(dvsr_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ring[head_reg] <= tr_c;
        end
        rdata_reg <= ring[rptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            seen_reg <= '0;
            prev_reg <= '0;
            ema_reg  <= '0;
            left_reg <= '0;
            rvld_reg <= 1'b0;
            pvld_reg <= 1'b0;
            dcnt_reg <= '0;
        end else begin
            if (cmd.load) begin
                prev_reg  <= close_price;
                first_reg <= first_c;
                tr_reg    <= tr_c;
                head_reg  <= (int'(head_reg) == atrf_pkg::MAX_WINDOW - 1) ? '0 : head_reg + 1'b1;
                if (first_c) begin
                    seen_reg <= CW'(1);
                end else if (int'(seen_reg) < atrf_pkg::MAX_WINDOW) begin
                    seen_reg <= seen_reg + 1'b1;
                end
            end
            if (cmd.ema_mul) begin
                pa_reg <= EPW'(ema_reg) * EPW'(atrf_pkg::ALPHA_ONE - a_eff);
                pb_reg <= EPW'(tr_reg) * EPW'(a_eff);
            end
            if (cmd.ema_upd) begin
                ema_reg <= first_reg ? tr_reg : PW'(ema_sum >> atrf_pkg::ALPHA_BITS);
            end

            // Window walk: read, weight, accumulate.
            rvld_reg <= 1'b0;
            if (cmd.sum_start) begin
                rptr_reg <= (head_reg == '0) ? IW'(atrf_pkg::MAX_WINDOW - 1) : head_reg - 1'b1;
                left_reg <= n_eff;
                wt_reg   <= n_eff;
                sum_reg  <= '0;
                wsum_reg <= '0;
            end else if (left_reg != '0) begin
                rvld_reg <= 1'b1;
                rwt_reg  <= wt_reg;
                rptr_reg <= (rptr_reg == '0) ? IW'(atrf_pkg::MAX_WINDOW - 1) : rptr_reg - 1'b1;
                wt_reg   <= wt_reg - 1'b1;
                left_reg <= left_reg - 1'b1;
            end
            pvld_reg <= rvld_reg;
            if (rvld_reg) begin
                prod_reg  <= (PW+CW)'(rdata_reg) * (PW+CW)'(rwt_reg);
                pdata_reg <= rdata_reg;
            end
            if (pvld_reg) begin
                sum_reg  <= sum_reg + SW'(pdata_reg);
                wsum_reg <= wsum_reg + WW'(prod_reg);
            end

            if (cmd.div_start) begin
                quo_reg  <= weighted ? wsum_reg : WW'(sum_reg);
                dvsr_reg <= weighted ? DW'(tri_prod >> 1) : DW'(n_eff);
                rem_reg  <= '0;
                dcnt_reg <= atrf_pkg::DCNT_W'(WW);
            end else if (dcnt_reg != '0) begin
                dcnt_reg <= dcnt_reg - 1'b1;
                if (!trial[DW+1]) begin
                    rem_reg <= DW'(trial);
                    quo_reg <= {quo_reg[WW-2:0], 1'b1};
                end else begin
                    rem_reg <= DW'(shift_rem);
                    quo_reg <= {quo_reg[WW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            tro_reg    <= tr_reg;
            full_o_reg <= full;
            if (mode == atrf_pkg::MODE_EMA) begin
                atr_reg <= ema_reg;
            end else if (full) begin
                atr_reg <= PW'(quo_reg);
            end else begin
                atr_reg <= '0;
            end
        end
    end

    assign stat.ema_mode = (mode == atrf_pkg::MODE_EMA);
    assign stat.full     = full;
    assign stat.sum_done = (left_reg == '0) && !rvld_reg && !pvld_reg;
    assign stat.div_done = (dcnt_reg == '0);

    assign atr_value   = atr_reg;
    assign bar_range   = tro_reg;
    assign window_full = full_o_reg;

endmodule

### rtl/atrf_checker.sv
module atrf_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready
);

    // A held result stays offered until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // One bar at a time: after a request is taken the input side closes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a bar is in work");

    // A result never appears in the cycle right after a bar is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result raised too early");

    // Reset empties the result side.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind average_true_range_filter_core atrf_checker u_atrf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
